[rtl/csazr_pkg.sv]
// Package for the color standard auto-zero and rescale block.
// Holds sizes, function codes and the sequencer state type; depends on nothing.
package csazr_pkg;

    localparam int NUM_STANDARDS = 8;
    localparam int NSTD_SLOTS    = NUM_STANDARDS - 1;
    localparam int SLOT_AW       = (NSTD_SLOTS > 1) ? $clog2(NSTD_SLOTS) : 1;

    localparam int NCH       = 4;
    localparam int CH_AW     = 2;
    localparam int CH_W      = 16;
    localparam int ROW_W     = NCH * CH_W;
    localparam int IDX_W     = 3;
    localparam int FUNC_W    = 2;
    localparam int GAIN_W    = 32;
    localparam int PROD_W    = CH_W + GAIN_W;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADJUST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [CH_AW-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_AW-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_AW-1:0] CH_LAST  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_CH_START,
        ST_DIV,
        ST_GAIN,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_WR,
        ST_NEXT_CH,
        ST_FINISH
    } state_t;

endpackage

[rtl/csazr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the standards table.
module csazr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 7,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/color_standard_auto_zero_rescale.sv]
// An auto-zero request steps through the channels in turn: a channel with a zero reference
// is flagged and left unscaled; otherwise a bit-per-cycle restoring divider forms its gain and
// one shared 16x32 multiplier rescales the standards one RAM row at a time. One request is
// in work at a time; s_ready is high only while idle. Reset (aresetn low, synchronous) clears
// the references to zero; the standards table is not cleared and holds unknown data until
// written.
module color_standard_auto_zero_rescale
    import csazr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [IDX_W-1:0]    s_entry_index,
    input  logic [CH_W-1:0]     s_red_value,
    input  logic [CH_W-1:0]     s_green_value,
    input  logic [CH_W-1:0]     s_blue_value,
    input  logic [CH_W-1:0]     s_clear_value,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [CH_W-1:0]     m_red_out,
    output logic [CH_W-1:0]     m_green_out,
    output logic [CH_W-1:0]     m_blue_out,
    output logic [CH_W-1:0]     m_clear_out,
    output logic [GAIN_W-1:0]   m_mean_gain,
    output logic [NCH-1:0]      m_zero_ref_flags
);

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CH_W-1:0]    val_reg [NCH];
    logic [CH_W-1:0]    val_next [NCH];
    logic [CH_W-1:0]    ref_reg [NCH];
    logic [CH_W-1:0]    ref_next [NCH];
    logic [CH_W-1:0]    res_reg [NCH];
    logic [CH_W-1:0]    res_next [NCH];
    logic [NCH-1:0]     flags_reg, flags_next;
    logic [GAIN_W:0]    sum_reg, sum_next;

    logic [CH_AW-1:0]   ch_reg, ch_next;
    logic [SLOT_AW-1:0] k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CH_W-1:0]    rem_reg, rem_next;
    logic [GAIN_W-1:0]  dq_reg, dq_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic               m_valid_reg, m_valid_next;
    logic [CH_W-1:0]    mout_reg [NCH];
    logic [CH_W-1:0]    mout_next [NCH];
    logic [GAIN_W-1:0]  mgain_reg, mgain_next;
    logic [NCH-1:0]     mflags_reg, mflags_next;

    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0]   ram_wdata, ram_rdata;

    logic [IDX_W-1:0]   idx_m1;
    logic [SLOT_AW-1:0] idx_slot;
    logic               idx_in_range;
    logic [CH_W:0]      trial;
    logic [CH_W:0]      divisor;
    logic               trial_ge;
    logic [CH_W-1:0]    scaled;
    logic [ROW_W-1:0]   row_vals;

    csazr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSTD_SLOTS),
        .AW    (SLOT_AW)
    ) u_std_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry 0 is the reference; standards live at RAM address index minus one.
    assign idx_m1       = idx_reg - IDX_W'(1);
    assign idx_slot     = SLOT_AW'(idx_m1);
    assign idx_in_range = (32'(idx_reg) < NUM_STANDARDS);

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign divisor  = {1'b0, ref_reg[ch_reg]};
    assign trial    = {rem_reg, dq_reg[GAIN_W-1]};
    assign trial_ge = (trial >= divisor);

    assign scaled = (|prod_reg[PROD_W-1:GAIN_W]) ? {CH_W{1'b1}} : prod_reg[GAIN_W-1:CH_W];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            row_vals[c*CH_W +: CH_W] = val_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                ref_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int c = 0; c < NCH; c++) begin
                ref_reg[c] <= ref_next[c];
            end
        end
        func_reg   <= func_next;
        idx_reg    <= idx_next;
        flags_reg  <= flags_next;
        sum_reg    <= sum_next;
        ch_reg     <= ch_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        prod_reg   <= prod_next;
        row_reg    <= row_next;
        mgain_reg  <= mgain_next;
        mflags_reg <= mflags_next;
        for (int c = 0; c < NCH; c++) begin
            val_reg[c]  <= val_next[c];
            res_reg[c]  <= res_next[c];
            mout_reg[c] <= mout_next[c];
        end
    end

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        idx_next     = idx_reg;
        flags_next   = flags_reg;
        sum_next     = sum_reg;
        ch_next      = ch_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        prod_next    = prod_reg;
        row_next     = row_reg;
        mgain_next   = mgain_reg;
        mflags_next  = mflags_reg;
        m_valid_next = m_valid_reg;
        for (int c = 0; c < NCH; c++) begin
            val_next[c]  = val_reg[c];
            ref_next[c]  = ref_reg[c];
            res_next[c]  = res_reg[c];
            mout_next[c] = mout_reg[c];
        end
        ram_we    = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = row_vals;
        ram_raddr = k_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next   = s_func;
                    idx_next    = s_entry_index;
                    val_next[0] = s_red_value;
                    val_next[1] = s_green_value;
                    val_next[2] = s_blue_value;
                    val_next[3] = s_clear_value;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE: begin
                flags_next = '0;
                sum_next   = '0;
                for (int c = 0; c < NCH; c++) begin
                    res_next[c] = '0;
                end
                state_next = ST_FINISH;
                unique case (func_reg)
                    FUNC_WRITE: begin
                        if (idx_reg == '0) begin
                            for (int c = 0; c < NCH; c++) begin
                                ref_next[c] = val_reg[c];
                                res_next[c] = val_reg[c];
                            end
                        end else if (idx_in_range) begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_slot;
                            ram_wdata = row_vals;
                            for (int c = 0; c < NCH; c++) begin
                                res_next[c] = val_reg[c];
                            end
                        end
                    end
                    FUNC_READ: begin
                        if (idx_reg == '0) begin
                            for (int c = 0; c < NCH; c++) begin
                                res_next[c] = ref_reg[c];
                            end
                        end else if (idx_in_range) begin
                            ram_raddr  = idx_slot;
                            state_next = ST_RD_WAIT;
                        end
                    end
                    FUNC_ADJUST: begin
                        for (int c = 0; c < NCH; c++) begin
                            res_next[c] = val_reg[c];
                        end
                        ch_next    = '0;
                        state_next = ST_CH_START;
                    end
                    default: begin
                    end
                endcase
            end

            ST_RD_WAIT: begin
                for (int c = 0; c < NCH; c++) begin
                    res_next[c] = ram_rdata[c*CH_W +: CH_W];
                end
                state_next = ST_FINISH;
            end

            ST_CH_START: begin
                if (ref_reg[ch_reg] == '0) begin
                    // No gain can be formed; the standards of this channel stay as they are.
                    flags_next[ch_reg] = 1'b1;
                    ref_next[ch_reg]   = val_reg[ch_reg];
                    state_next         = ST_NEXT_CH;
                end else begin
                    rem_next   = '0;
                    dq_next    = {val_reg[ch_reg], {CH_W{1'b0}}};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                if (trial_ge) begin
                    rem_next = CH_W'(trial - divisor);
                end else begin
                    rem_next = trial[CH_W-1:0];
                end
                dq_next  = {dq_reg[GAIN_W-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_GAIN;
                end
            end

            ST_GAIN: begin
                // The quotient now sits in dq_reg and serves as the gain for this channel.
                if (ch_reg == CH_GREEN || ch_reg == CH_BLUE) begin
                    sum_next = sum_reg + {1'b0, dq_reg};
                end
                ref_next[ch_reg] = val_reg[ch_reg];
                k_next           = '0;
                state_next       = ST_SC_RD;
            end

            ST_SC_RD: begin
                ram_raddr  = k_reg;
                state_next = ST_SC_MUL;
            end

            ST_SC_MUL: begin
                row_next   = ram_rdata;
                prod_next  = PROD_W'(ram_rdata[ch_reg*CH_W +: CH_W]) * PROD_W'(dq_reg);
                state_next = ST_SC_WR;
            end

            ST_SC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = row_reg;
                ram_wdata[ch_reg*CH_W +: CH_W] = scaled;
                if (k_reg == SLOT_AW'(NSTD_SLOTS - 1)) begin
                    state_next = ST_NEXT_CH;
                end else begin
                    k_next     = k_reg + SLOT_AW'(1);
                    state_next = ST_SC_RD;
                end
            end

            ST_NEXT_CH: begin
                if (ch_reg == CH_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    ch_next    = ch_reg + CH_AW'(1);
                    state_next = ST_CH_START;
                end
            end

            ST_FINISH: begin
                // Wait until the output register is free, then hand the result over.
                if (!m_valid_reg || m_ready) begin
                    for (int c = 0; c < NCH; c++) begin
                        mout_next[c] = res_reg[c];
                    end
                    mgain_next   = sum_reg[GAIN_W:1];
                    mflags_next  = flags_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_red_out        = mout_reg[0];
    assign m_green_out      = mout_reg[1];
    assign m_blue_out       = mout_reg[2];
    assign m_clear_out      = mout_reg[3];
    assign m_mean_gain      = mgain_reg;
    assign m_zero_ref_flags = mflags_reg;

    // A new request is never taken in the cycle right after one was accepted.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");

    // The divider only runs against a nonzero reference, and its remainder stays below it.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (ref_reg[ch_reg] != '0 && rem_reg < ref_reg[ch_reg]))
        else $error("divider running with bad divisor or remainder");

    // The table is written only on a write request or while rescaling.
    a_ram_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_DECODE || state_reg == ST_SC_WR))
        else $error("standards table written outside write or rescale");

    // With both green and blue references zero there is no gain to average.
    a_mean_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_ref_flags[1] && m_zero_ref_flags[2]) |-> (m_mean_gain == '0))
        else $error("mean gain nonzero without green or blue gain");

    // A result is loaded only when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_valid_reg && !m_ready) |=> (state_reg == ST_FINISH))
        else $error("pending result overwritten");

endmodule
